[sv/modular_exponentiation_assert.svh]
// ------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property wrappers for the concurrent checks of the block
// ------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// property checked on every clock edge outside reset
`define MODEXP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("modexp assertion failed");

// property checked on every clock edge, reset included
`define MODEXP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("modexp assertion failed");

`endif

[sv/modexp_pkg.sv]
// ------------------------------------------------------------------------
// modexp_pkg
// widths for the exponentiation sequencer and the modular multiplier
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

   localparam int OPERAND_WIDTH = 31;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

endpackage

`default_nettype wire

[sv/modexp_mulmod.sv]
// ------------------------------------------------------------------------
// modexp_mulmod
// bit-serial modular multiplier: one multiplier bit per cycle, msb first,
// the accumulator kept below the modulus after every step
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulmod
   import modexp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     op_start,
   input  wire logic [OPERAND_WIDTH-1:0] op_x,
   input  wire logic [OPERAND_WIDTH-1:0] op_y,
   input  wire logic [OPERAND_WIDTH-1:0] op_mod,
   output logic                          op_done,
   output logic [OPERAND_WIDTH-1:0]      op_product
);

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         y_ff, y_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [W+1:0] sum_w, diff1_w, diff2_w, mod1_w, mod2_w;

   // 2*acc + bit*x stays below 3*m, so one of three candidates is the residue
   always_comb begin
      mod1_w  = {2'b00, op_mod};
      mod2_w  = {1'b0, op_mod, 1'b0};
      sum_w   = {1'b0, acc_ff, 1'b0} + (y_ff[W-1] ? {2'b00, op_x} : '0);
      diff1_w = sum_w - mod1_w;
      diff2_w = sum_w - mod2_w;
   end

   always_comb begin
      acc_in  = acc_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (op_start) begin
         acc_in = '0;
         y_in   = op_y;
         cnt_in = CNT_WIDTH'(W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (sum_w >= mod2_w) begin
            acc_in = diff2_w[W-1:0];
         end else if (sum_w >= mod1_w) begin
            acc_in = diff1_w[W-1:0];
         end else begin
            acc_in = sum_w[W-1:0];
         end
         y_in = {y_ff[W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      y_ff   <= y_in;
   end

   assign op_done    = done_ff;
   assign op_product = acc_ff;

endmodule

`default_nettype wire

[sv/modular_exponentiation.sv]
// ------------------------------------------------------------------------
// modular_exponentiation
// right-to-left square-and-multiply over a shared bit-serial modular
// multiplier; base, exponent and modulus arrive with each item
//
//   channel  | ports                               | handshake
//   request  | req_base/exponent/modulus_value     | start high, busy low
//   response | rsp_power_result                    | rsp_valid, one cycle
//
// an item takes bits + ones multiplications, bits being the exponent
// length and ones its set bits; each multiplication is started from a
// register, steps through the operand one multiplier bit at a time and
// hands back its product through a registered done flag
// exponent zero or modulus zero strobes in the cycle after acceptance
// busy stays high from acceptance until the result strobe has gone
// synchronous reset returns the sequencer and the multiplier to idle
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
   import modexp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [OPERAND_WIDTH-1:0] req_base_value,
   input  wire logic [OPERAND_WIDTH-1:0] req_exponent_value,
   input  wire logic [OPERAND_WIDTH-1:0] req_modulus_value,
   output logic                          rsp_valid,
   output logic [OPERAND_WIDTH-1:0]      rsp_power_result
);

   localparam int W = OPERAND_WIDTH;
   localparam logic [W-1:0] ONE_VALUE = {{(W-1){1'b0}}, 1'b1};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_MULR   = 5'b00100,
      ST_MULS   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] square_ff, square_in;
   logic [W-1:0] result_ff, result_in;
   logic         mm_start_ff, mm_start_in;

   logic         mm_done;
   logic [W-1:0] mm_product;
   logic [W-1:0] mm_x, mm_y;
   logic [W-1:0] exp_shift;

   // operand selection for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_REDUCE: begin
            mm_x = ONE_VALUE;
            mm_y = base_ff;
         end
         ST_MULR: begin
            mm_x = result_ff;
            mm_y = square_ff;
         end
         default: begin
            mm_x = square_ff;
            mm_y = square_ff;
         end
      endcase
   end

   modexp_mulmod u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .op_start   (mm_start_ff),
      .op_x       (mm_x),
      .op_y       (mm_y),
      .op_mod     (mod_ff),
      .op_done    (mm_done),
      .op_product (mm_product)
   );

   assign exp_shift = {1'b0, exp_ff[W-1:1]};

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      exp_in      = exp_ff;
      mod_in      = mod_ff;
      square_in   = square_ff;
      result_in   = result_ff;
      mm_start_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               base_in = req_base_value;
               exp_in  = req_exponent_value;
               mod_in  = req_modulus_value;
               if (req_exponent_value == '0) begin
                  result_in = ONE_VALUE;
                  state_in  = ST_DONE;
               end else if (req_modulus_value == '0) begin
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  // 1 mod m
                  result_in   = (req_modulus_value == ONE_VALUE) ? '0 : ONE_VALUE;
                  state_in    = ST_REDUCE;
                  mm_start_in = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               square_in   = mm_product;
               state_in    = exp_ff[0] ? ST_MULR : ST_MULS;
               mm_start_in = 1'b1;
            end
         end
         ST_MULR: begin
            if (mm_done) begin
               result_in = mm_product;
               // last set bit: the final squaring is not needed
               if (exp_shift == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in    = ST_MULS;
                  mm_start_in = 1'b1;
               end
            end
         end
         ST_MULS: begin
            if (mm_done) begin
               square_in = mm_product;
               exp_in    = exp_shift;
               if (exp_shift == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in    = exp_shift[0] ? ST_MULR : ST_MULS;
                  mm_start_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mm_start_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mm_start_ff <= mm_start_in;
      end
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      mod_ff    <= mod_in;
      square_ff <= square_in;
      result_ff <= result_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_power_result = result_ff;

   `MODEXP_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid)
   `MODEXP_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `MODEXP_ASSERT(a_zero_exponent, clock, reset,
      (start && !busy && req_exponent_value == '0) |=>
      (rsp_valid && rsp_power_result == ONE_VALUE))
   `MODEXP_ASSERT(a_mul_done_in_use, clock, reset,
      mm_done |-> (state_ff == ST_REDUCE || state_ff == ST_MULR || state_ff == ST_MULS))
   `MODEXP_ASSERT_ALWAYS(a_result_below_mod, clock,
      (rsp_valid && !reset && mod_ff != '0 && exp_ff != '0) |->
      (rsp_power_result < mod_ff))

endmodule

`default_nettype wire

[tb/modular_exponentiation_test.sv]
// ------------------------------------------------------------------------
// modular_exponentiation_test
// self-checking bench for the square-and-multiply exponentiator: directed
// corner items, then random bursts of items with random gaps; every result
// is checked against an exact 64-bit predictor, oldest item first
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_test;
   import modexp_pkg::*;

   typedef bit [OPERAND_WIDTH-1:0] operand_type;

   localparam operand_type OPERAND_MAX = '1;
   localparam int          RANDOM_ITEMS = 270;
   localparam int          DRAIN_EVERY = 70;
   localparam int          TAIL_CYCLES = 100;

   typedef struct {
      operand_type base_value;
      operand_type exponent_value;
      operand_type modulus_value;
      operand_type power_result;
   } power_item_type;

   class power_checker_type;
      power_item_type expected_powers[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      // exact products fit easily: both factors stay below 2^31
      function operand_type power_mod(operand_type b, operand_type e, operand_type m);
         longint unsigned acc, sq, mm;
         operand_type     rest;
         if (e == 0) return operand_type'(1);
         if (m == 0) return '0;
         mm   = m;
         sq   = b % mm;
         acc  = 1 % mm;
         rest = e;
         while (rest != 0) begin
            if (rest[0]) acc = (acc * sq) % mm;
            sq   = (sq * sq) % mm;
            rest = rest >> 1;
         end
         return operand_type'(acc);
      endfunction

      function void note_item(operand_type b, operand_type e, operand_type m);
         power_item_type it;
         it.base_value     = b;
         it.exponent_value = e;
         it.modulus_value  = m;
         it.power_result   = power_mod(b, e, m);
         expected_powers.insert(expected_powers.size(), it);
      endfunction

      function void check_result(operand_type actual);
         power_item_type it;
         if (expected_powers.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d",
                     $realtime, actual);
            errors++;
            return;
         end
         it = expected_powers.pop_front();
         if (actual !== it.power_result) begin
            $display("%0t: power_result mismatch (base %0d exp %0d mod %0d): %s %0d, %s %0d",
                     $realtime, it.base_value, it.exponent_value, it.modulus_value,
                     "expected", it.power_result, "actual", actual);
            errors++;
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OPERAND_WIDTH-1:0] req_base_value;
   logic [OPERAND_WIDTH-1:0] req_exponent_value;
   logic [OPERAND_WIDTH-1:0] req_modulus_value;
   logic                     rsp_valid;
   logic [OPERAND_WIDTH-1:0] rsp_power_result;

   power_checker_type ledger;

   modular_exponentiation dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_power_result   (rsp_power_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // item accepted and result strobe, both seen with pre-edge values
   always @(posedge clock) begin
      if (!reset && start && !busy)
         ledger.note_item(req_base_value, req_exponent_value, req_modulus_value);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         ledger.check_result(rsp_power_result);
   end

   // start stays high until the item is taken; a following call keeps it high
   task automatic send_power(operand_type b, operand_type e, operand_type m);
      @(negedge clock);
      start              <= 1'b1;
      req_base_value     <= b;
      req_exponent_value <= e;
      req_modulus_value  <= m;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_powers();
      idle_for(1);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_power();
      operand_type b, e, m;
      case ($urandom_range(0, 3))
         0: b = operand_type'($urandom_range(0, 3));
         1: b = operand_type'(OPERAND_MAX - $urandom_range(0, 15));
         default: b = operand_type'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: e = operand_type'($urandom_range(0, 15));
         1: e = operand_type'($urandom & ((32'h1 << $urandom_range(1, 31)) - 1));
         default: e = operand_type'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: m = operand_type'($urandom_range(1, 64));
         1: m = operand_type'(OPERAND_MAX - $urandom_range(0, 15));
         2: m = operand_type'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
         default: begin
            m = operand_type'($urandom);
            if (m == 0) m = 1;
         end
      endcase
      send_power(b, e, m);
   endtask

   initial begin
      int sent, burst;
      ledger             = new();
      reset              = 1'b1;
      start              = 1'b0;
      req_base_value     = '0;
      req_exponent_value = '0;
      req_modulus_value  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero exponent returns one whatever the modulus
      send_power(5, 0, 1);
      send_power(0, 0, 0);
      send_power(OPERAND_MAX, 0, OPERAND_MAX);
      send_power(0, 0, 7);
      // zero modulus with nonzero exponent
      send_power(9, 5, 0);
      send_power(OPERAND_MAX, OPERAND_MAX, 0);
      // unit modulus
      send_power(7, 1, 1);
      send_power(OPERAND_MAX, OPERAND_MAX, 1);
      // base at, above and below the modulus
      send_power(OPERAND_MAX, 1, 1000);
      send_power(12345, 1, 12345);
      send_power(0, 1, 13);
      send_power(1, OPERAND_MAX, OPERAND_MAX);
      send_power(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
      send_power(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX - 1);
      send_power(OPERAND_MAX - 1, 2, OPERAND_MAX);
      send_power(2, 30, OPERAND_MAX);
      send_power(3, OPERAND_MAX, 2);
      // 2^31-1 is prime, so this one comes back as one
      send_power(2, OPERAND_MAX - 1, OPERAND_MAX);
      send_power(OPERAND_MAX, operand_type'(1) << (OPERAND_WIDTH - 1), OPERAND_MAX - 2);
      drain_powers();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            send_random_power();
            sent++;
            if (sent % DRAIN_EVERY == 0) drain_powers();
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 20));
      end

      drain_powers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/modexp_pkg.sv
sv/modexp_mulmod.sv
sv/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
